>>> sv/jcdc_pkg.sv
package jcdc_pkg;

	// Field widths of the ports
	localparam int FRAC_W  = 32;
	localparam int YEAR_W  = 15;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int MJD_W   = 23;
	localparam int DOY_W   = 9;

	// Number of fraction bits kept; the port is always FRAC_W wide
	localparam int FRACTION_BITS = 32;
	localparam logic [FRAC_W-1:0] FRAC_MASK = (FRACTION_BITS >= FRAC_W) ? {FRAC_W{1'b1}} :
		FRAC_W'((64'd1 << FRACTION_BITS) - 64'd1);

	// Operation codes
	localparam logic OP_DATE_TO_MJD = 1'b0;
	localparam logic OP_MJD_TO_DATE = 1'b1;

	// Date to MJD
	localparam int YEAR_SWITCH  = 1582;
	localparam int MONTH_SWITCH = 10;
	localparam int DAY_SWITCH   = 15;
	localparam int JD_YEAR_OFS  = 4716;
	localparam int MJD_BIAS     = 2401525;

	// MJD to date
	localparam int JD_DAY_OFS   = 2400001;
	localparam int JD_GREG      = 2299161;
	localparam int ALPHA_OFS    = 7468865;
	localparam int B_OFS        = 1524;
	// 20*b - 2442 plus 4909 * 7305 keeps the dividend non-negative
	localparam int C_BIAS       = 4909;
	localparam int C_OFS        = C_BIAS * 7305 - 2442;
	localparam int YEAR_OFS_LO  = 4715;
	localparam int YEAR_OFS_HI  = 4716;

	// Biased division by 100: year + 100*BIAS is always non-negative
	localparam int Y100_BIAS    = 164;
	localparam int YR100_BIAS   = 100;

	// Reciprocals: floor(x/D) = (x*K) >> SH, exact for x < 2^(SH - ceil(log2 D))
	localparam int DIV100_SH = 23;
	localparam logic [16:0] DIV100_K =
		17'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
	localparam int ALPHA_SH = 43;
	localparam logic [25:0] ALPHA_K =
		26'(((64'd1 << ALPHA_SH) + 64'd146096) / 64'd146097);
	localparam int C_SH = 41;
	localparam logic [28:0] C_K =
		29'(((64'd1 << C_SH) + 64'd7304) / 64'd7305);
	// 10000 folded into the reciprocal of 306001
	localparam int E_SH = 42;
	localparam logic [37:0] E_K =
		38'((((64'd1 << E_SH) + 64'd306000) / 64'd306001) * 64'd10000);

	// floor(30.6001 * k)
	function automatic logic [8:0] mon_offset(input logic [4:0] k);
		logic [8:0] v;
		case (k)
			5'd1:    v = 9'd30;
			5'd2:    v = 9'd61;
			5'd3:    v = 9'd91;
			5'd4:    v = 9'd122;
			5'd5:    v = 9'd153;
			5'd6:    v = 9'd183;
			5'd7:    v = 9'd214;
			5'd8:    v = 9'd244;
			5'd9:    v = 9'd275;
			5'd10:   v = 9'd306;
			5'd11:   v = 9'd336;
			5'd12:   v = 9'd367;
			5'd13:   v = 9'd397;
			5'd14:   v = 9'd428;
			5'd15:   v = 9'd459;
			5'd16:   v = 9'd489;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// floor(275 * month / 9)
	function automatic logic [8:0] doy_base(input logic [3:0] m);
		logic [8:0] v;
		case (m)
			4'd1:    v = 9'd30;
			4'd2:    v = 9'd61;
			4'd3:    v = 9'd91;
			4'd4:    v = 9'd122;
			4'd5:    v = 9'd152;
			4'd6:    v = 9'd183;
			4'd7:    v = 9'd213;
			4'd8:    v = 9'd244;
			4'd9:    v = 9'd275;
			4'd10:   v = 9'd305;
			4'd11:   v = 9'd336;
			4'd12:   v = 9'd366;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

>>> sv/julian_calendar_date_converter.sv
// Channel   Handshake          Beat payload
// command   start / busy       opcode, cal_year, cal_month, cal_day, in_fraction, in_mjd_day
// result    done (strobe)      out_mjd_day, out_year, out_month, out_day,
//                              out_day_of_year, out_fraction
//
// A beat is taken at every edge where start is high; busy is always low,
// so one conversion enters per clock.
// Each result passes one input register, five pipeline stages and the
// result register on its way out. The depth is set by the chain
// of constant multiplies (alpha, c, d, e, year/100), one per stage.
// Reset clears only the valid bits and the strobe; payload flops run free.
// The receiver cannot stall: done is high for exactly one cycle per beat.
module julian_calendar_date_converter (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    opcode,
	input  logic signed [jcdc_pkg::YEAR_W-1:0]      cal_year,
	input  logic        [jcdc_pkg::MONTH_W-1:0]     cal_month,
	input  logic        [jcdc_pkg::DAY_W-1:0]       cal_day,
	input  logic        [jcdc_pkg::FRAC_W-1:0]      in_fraction,
	input  logic signed [jcdc_pkg::MJD_W-1:0]       in_mjd_day,
	output logic                                    done,
	output logic signed [jcdc_pkg::MJD_W-1:0]       out_mjd_day,
	output logic signed [jcdc_pkg::YEAR_W-1:0]      out_year,
	output logic        [jcdc_pkg::MONTH_W-1:0]     out_month,
	output logic        [jcdc_pkg::DAY_W-1:0]       out_day,
	output logic        [jcdc_pkg::DOY_W-1:0]       out_day_of_year,
	output logic        [jcdc_pkg::FRAC_W-1:0]      out_fraction
);

	// ------------------------------------------------------------------
	// Stage registers
	// ------------------------------------------------------------------
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                     op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic [jcdc_pkg::FRAC_W-1:0] frac_s1, frac_s2, frac_s3, frac_s4, frac_s5, frac_s6;

	logic signed [14:0]       year_s1;
	logic [3:0]               month_s1;
	logic [4:0]               day_s1;
	logic signed [22:0]       mjd_s1;

	logic signed [15:0]       y_s2;
	logic [3:0]               m_s2;
	logic [4:0]               d_s2;
	logic signed [9:0]        a100_s2;
	logic signed [23:0]       z_s2;
	logic                     greg_s2;
	logic [7:0]               alpha_s2;

	logic [22:0]              whole_s3, whole_s4, whole_s5, whole_s6;
	logic signed [23:0]       b_s3;
	logic signed [15:0]       c_s3, c_s4, c_s5;
	logic                     greg_s3, greg_s4, greg_s5, greg_s6;

	logic [8:0]               bd_s4, bd_s5;
	logic [3:0]               e_s5;

	logic signed [14:0]       yr_s6;
	logic [14:0]              yx_s6;
	logic [7:0]               q100_s6;
	logic [3:0]               mon_s6;
	logic [4:0]               dom_s6;

	logic                     done_q;
	logic [22:0]              out_mjd_day_q;
	logic [14:0]              out_year_q;
	logic [3:0]               out_month_q;
	logic [4:0]               out_day_q;
	logic [8:0]               out_day_of_year_q;
	logic [31:0]              out_fraction_q;

	// ------------------------------------------------------------------
	// Stage 1 -> 2: month shift, year/100, z, alpha
	// ------------------------------------------------------------------
	logic signed [15:0] y_adj;
	logic [3:0]         m_adj;
	logic [15:0]        x100;
	logic [32:0]        p100;
	logic [9:0]         q100_a;
	logic signed [23:0] z_c;
	logic signed [26:0] ax_c;
	logic [50:0]        palpha;

	always_comb begin
		// move January and February to the end of the previous year
		if (month_s1 < 4'd3) begin
			y_adj = 16'(year_s1) - 16'sd1;
			m_adj = month_s1 + 4'd12;
		end else begin
			y_adj = 16'(year_s1);
			m_adj = month_s1;
		end
		x100   = 16'(y_adj) + 16'(jcdc_pkg::Y100_BIAS * 100);
		p100   = 33'(x100) * 33'(jcdc_pkg::DIV100_K);
		q100_a = p100[jcdc_pkg::DIV100_SH +: 10];

		z_c    = 24'(mjd_s1) + 24'(jcdc_pkg::JD_DAY_OFS);
		ax_c   = (27'(z_c) <<< 2) - 27'(jcdc_pkg::ALPHA_OFS);
		palpha = 51'(ax_c[24:0]) * 51'(jcdc_pkg::ALPHA_K);
	end

	// ------------------------------------------------------------------
	// Stage 2 -> 3: whole MJD for date input; b and c for MJD input
	// ------------------------------------------------------------------
	logic signed [9:0]  b0_c;
	logic               julian_c;
	logic signed [16:0] yp_c;
	logic signed [28:0] t_prod;
	logic signed [31:0] t32, mo32, d32, b32, whole_c;
	logic signed [23:0] alpha24, a_c, b_c;
	logic signed [29:0] cx_c;
	logic [56:0]        pc;
	logic signed [15:0] c_c;

	always_comb begin
		b0_c     = 10'sd2 - a100_s2 + (a100_s2 >>> 2);
		julian_c = (y_s2 < 16'(jcdc_pkg::YEAR_SWITCH)) ||
			((y_s2 == 16'(jcdc_pkg::YEAR_SWITCH)) && (m_s2 < 4'(jcdc_pkg::MONTH_SWITCH))) ||
			((y_s2 == 16'(jcdc_pkg::YEAR_SWITCH)) && (m_s2 == 4'(jcdc_pkg::MONTH_SWITCH)) &&
			 (d_s2 < 5'(jcdc_pkg::DAY_SWITCH)));
		yp_c     = 17'(y_s2) + 17'(jcdc_pkg::JD_YEAR_OFS);
		t_prod   = 29'(yp_c) * 29'sd1461;
		t32      = 32'(t_prod >>> 2);
		mo32     = $signed({23'd0, jcdc_pkg::mon_offset({1'b0, m_s2} + 5'd1)});
		d32      = $signed({27'd0, d_s2});
		b32      = julian_c ? 32'sd0 : 32'(b0_c);
		whole_c  = t32 + mo32 + d32 + b32 - 32'(jcdc_pkg::MJD_BIAS);

		alpha24  = $signed({16'd0, alpha_s2});
		a_c      = greg_s2 ? (z_s2 + 24'sd1 + alpha24 - (alpha24 >>> 2)) : z_s2;
		b_c      = a_c + 24'(jcdc_pkg::B_OFS);
		cx_c     = (30'(b_c) * 30'sd20) + 30'(jcdc_pkg::C_OFS);
		pc       = 57'(cx_c[27:0]) * 57'(jcdc_pkg::C_K);
		c_c      = $signed(pc[jcdc_pkg::C_SH +: 16]) - 16'(jcdc_pkg::C_BIAS);
	end

	// ------------------------------------------------------------------
	// Stage 3 -> 4: day within the four-year cycle
	// ------------------------------------------------------------------
	logic signed [26:0] dprod;
	logic signed [26:0] bd_full;

	always_comb begin
		dprod   = 27'(c_s3) * 27'sd1461;
		bd_full = 27'(b_s3) - (dprod >>> 2);
	end

	// ------------------------------------------------------------------
	// Stage 4 -> 5: month index e
	// ------------------------------------------------------------------
	logic [46:0] pe;

	assign pe = 47'(bd_s4) * 47'(jcdc_pkg::E_K);

	// ------------------------------------------------------------------
	// Stage 5 -> 6: month, year, day, year/100
	// ------------------------------------------------------------------
	logic [3:0]         mon_c;
	logic signed [15:0] yr_c;
	logic [4:0]         dom_c;
	logic [14:0]        yx_c;
	logic [31:0]        py;

	always_comb begin
		if (e_s5 < 4'd14) begin
			mon_c = e_s5 - 4'd1;
			yr_c  = c_s5 - 16'(jcdc_pkg::YEAR_OFS_HI);
		end else begin
			mon_c = e_s5 - 4'd13;
			yr_c  = c_s5 - 16'(jcdc_pkg::YEAR_OFS_LO);
		end
		dom_c = 5'(bd_s5 - jcdc_pkg::mon_offset({1'b0, e_s5}));
		yx_c  = 15'(yr_c + 16'(jcdc_pkg::YR100_BIAS * 100));
		py    = 32'(yx_c) * 32'(jcdc_pkg::DIV100_K);
	end

	// ------------------------------------------------------------------
	// Stage 6 -> result: leap rule and day of year
	// ------------------------------------------------------------------
	logic               rem_zero, div4, leap;
	logic [1:0]         feb_adj;
	logic signed [10:0] doy_c;

	always_comb begin
		rem_zero = (yx_s6 == 15'({7'd0, q100_s6} * 15'd100));
		div4     = (yr_s6[1:0] == 2'd0);
		// Gregorian: by 4 and not by 100, or by 400; Julian: by 4
		leap     = greg_s6 ? ((div4 && !rem_zero) || (rem_zero && (q100_s6[1:0] == 2'd0)))
			: div4;
		if (mon_s6 < 4'd3) begin
			feb_adj = 2'd0;
		end else if (leap) begin
			feb_adj = 2'd1;
		end else begin
			feb_adj = 2'd2;
		end
		doy_c = $signed({2'b00, jcdc_pkg::doy_base(mon_s6)}) - $signed({9'd0, feb_adj}) +
			$signed({6'd0, dom_s6}) - 11'sd30;
	end

	// ------------------------------------------------------------------
	// Valid chain and strobe
	// ------------------------------------------------------------------
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			done_q <= vld_s6;
		end
	end

	// ------------------------------------------------------------------
	// Payload pipeline: no reset; the input register loads on a beat, the rest advance every cycle
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		// capture the beat
		if (start && !busy) begin
			op_s1    <= opcode;
			year_s1  <= cal_year;
			month_s1 <= cal_month;
			day_s1   <= cal_day;
			frac_s1  <= in_fraction & jcdc_pkg::FRAC_MASK;
			mjd_s1   <= in_mjd_day;
		end

		op_s2    <= op_s1;
		frac_s2  <= frac_s1;
		y_s2     <= y_adj;
		m_s2     <= m_adj;
		d_s2     <= day_s1;
		a100_s2  <= $signed(q100_a) - 10'(jcdc_pkg::Y100_BIAS);
		z_s2     <= z_c;
		greg_s2  <= (z_c >= 24'(jcdc_pkg::JD_GREG));
		alpha_s2 <= palpha[jcdc_pkg::ALPHA_SH +: 8];

		op_s3    <= op_s2;
		frac_s3  <= frac_s2;
		whole_s3 <= whole_c[22:0];
		b_s3     <= b_c;
		c_s3     <= c_c;
		greg_s3  <= greg_s2;

		op_s4    <= op_s3;
		frac_s4  <= frac_s3;
		whole_s4 <= whole_s3;
		c_s4     <= c_s3;
		bd_s4    <= bd_full[8:0];
		greg_s4  <= greg_s3;

		op_s5    <= op_s4;
		frac_s5  <= frac_s4;
		whole_s5 <= whole_s4;
		c_s5     <= c_s4;
		bd_s5    <= bd_s4;
		e_s5     <= pe[jcdc_pkg::E_SH +: 4];
		greg_s5  <= greg_s4;

		op_s6    <= op_s5;
		frac_s6  <= frac_s5;
		whole_s6 <= whole_s5;
		yr_s6    <= yr_c[14:0];
		yx_s6    <= yx_c;
		q100_s6  <= py[jcdc_pkg::DIV100_SH +: 8];
		mon_s6   <= mon_c;
		dom_s6   <= dom_c;
		greg_s6  <= greg_s5;

		// result register: zero the fields the other opcode does not produce
		out_fraction_q <= frac_s6;
		if (op_s6 == jcdc_pkg::OP_DATE_TO_MJD) begin
			out_mjd_day_q     <= whole_s6;
			out_year_q        <= '0;
			out_month_q       <= '0;
			out_day_q         <= '0;
			out_day_of_year_q <= '0;
		end else begin
			out_mjd_day_q     <= '0;
			out_year_q        <= yr_s6;
			out_month_q       <= mon_s6;
			out_day_q         <= dom_s6;
			out_day_of_year_q <= doy_c[8:0];
		end
	end

	assign done            = done_q;
	assign out_mjd_day     = $signed(out_mjd_day_q);
	assign out_year        = $signed(out_year_q);
	assign out_month       = out_month_q;
	assign out_day         = out_day_q;
	assign out_day_of_year = out_day_of_year_q;
	assign out_fraction    = out_fraction_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##7 done)
		else $error("result strobe missing seven clocks after command");

	a_cycle_day: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (bd_s4 >= 9'd123 && bd_s4 <= 9'd488))
		else $error("day within cycle out of range");

	a_month_idx: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (e_s5 >= 4'd4 && e_s5 <= 4'd15))
		else $error("month index out of range");

	a_result_split: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((out_month_q >= 4'd1 && out_month_q <= 4'd12 && out_day_q >= 5'd1 &&
			out_mjd_day_q == 23'd0) ||
			(out_month_q == 4'd0 && out_year_q == 15'd0 && out_day_q == 5'd0 &&
			out_day_of_year_q == 9'd0)))
		else $error("result fields mix both conversions");

endmodule

>>> tb/sv/tb_julian_calendar_date_converter.sv
`timescale 1ns / 100ps

module tb_julian_calendar_date_converter;

	// Calendar anchors used by the predictor
	localparam longint JD_OF_MJD0   = 2400001;   // JD whole day at MJD 0 noon-split
	localparam longint JD_FIRST_GREG = 2299161;  // first Gregorian JD day, 1582-10-15
	localparam longint MJD_OF_JD    = 2401525;   // JD bias plus the 1524 day shift
	localparam int     LAST_GAP     = 15;        // longest sender pause in cycles
	localparam int     DRAIN_CYCLES = 16;        // settle time after the last result

	// One command beat as the sender sees it, plus its lead-in pause
	typedef struct {
		logic                                 op;
		logic signed [jcdc_pkg::YEAR_W-1:0]   year;
		logic        [jcdc_pkg::MONTH_W-1:0]  month;
		logic        [jcdc_pkg::DAY_W-1:0]    day;
		logic        [jcdc_pkg::FRAC_W-1:0]   frac;
		logic signed [jcdc_pkg::MJD_W-1:0]    mjd;
		int unsigned                          gap;
	} conv_cmd_t;

	// One result beat
	typedef struct {
		logic signed [jcdc_pkg::MJD_W-1:0]    mjd;
		logic signed [jcdc_pkg::YEAR_W-1:0]   year;
		logic        [jcdc_pkg::MONTH_W-1:0]  month;
		logic        [jcdc_pkg::DAY_W-1:0]    day;
		logic        [jcdc_pkg::DOY_W-1:0]    doy;
		logic        [jcdc_pkg::FRAC_W-1:0]   frac;
	} conv_res_t;

	// Drive every input to a known value from time zero
	logic                                 clk         = 1'b0;
	logic                                 arst_n      = 1'b0;
	logic                                 start       = 1'b0;
	logic                                 opcode      = jcdc_pkg::OP_DATE_TO_MJD;
	logic signed [jcdc_pkg::YEAR_W-1:0]   cal_year    = '0;
	logic        [jcdc_pkg::MONTH_W-1:0]  cal_month   = '0;
	logic        [jcdc_pkg::DAY_W-1:0]    cal_day     = '0;
	logic        [jcdc_pkg::FRAC_W-1:0]   in_fraction = '0;
	logic signed [jcdc_pkg::MJD_W-1:0]    in_mjd_day  = '0;

	logic                                 busy;
	logic                                 done;
	logic signed [jcdc_pkg::MJD_W-1:0]    out_mjd_day;
	logic signed [jcdc_pkg::YEAR_W-1:0]   out_year;
	logic        [jcdc_pkg::MONTH_W-1:0]  out_month;
	logic        [jcdc_pkg::DAY_W-1:0]    out_day;
	logic        [jcdc_pkg::DOY_W-1:0]    out_day_of_year;
	logic        [jcdc_pkg::FRAC_W-1:0]   out_fraction;

	conv_cmd_t   pending_cmds[$];    // commands not yet offered to the block
	conv_res_t   expected_dates[$];  // predicted results in beat order
	int          fail_cnt    = 0;
	logic        beat_taken  = 1'b0; // last offered command went in at the previous edge
	int unsigned gap_left    = 0;
	bit          gap_armed   = 1'b0;
	bit          burst_run   = 1'b0; // stretch of back-to-back beats
	conv_cmd_t   drv_cmd;
	conv_cmd_t   mon_cmd;
	conv_res_t   got_res;
	conv_res_t   want_res;

	always #4 clk = ~clk;

	julian_calendar_date_converter uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.cal_year        (cal_year),
		.cal_month       (cal_month),
		.cal_day         (cal_day),
		.in_fraction     (in_fraction),
		.in_mjd_day      (in_mjd_day),
		.done            (done),
		.out_mjd_day     (out_mjd_day),
		.out_year        (out_year),
		.out_month       (out_month),
		.out_day         (out_day),
		.out_day_of_year (out_day_of_year),
		.out_fraction    (out_fraction)
	);

	// Floor division; the divisors here are always positive
	function automatic longint floor_div(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint floor_mod(input longint a, input longint b);
		return a - floor_div(a, b) * b;
	endfunction

	// Compute the expected result of one conversion
	function automatic conv_res_t convert_date(input conv_cmd_t c);
		conv_res_t r;
		longint    y, m, d, a, b, whole;
		longint    z, alpha, cc, dd, e, dom, mon, yr, k;
		bit        greg, leap;
		r = '{default: '0};
		r.frac = c.frac & jcdc_pkg::FRAC_MASK;
		if (c.op == jcdc_pkg::OP_DATE_TO_MJD) begin
			y = longint'(c.year);
			m = longint'(c.month);
			d = longint'(c.day);
			// January and February count as months 13 and 14 of the prior year
			if (m < 3) begin
				y = y - 1;
				m = m + 12;
			end
			a = floor_div(y, 100);
			b = 2 - a + floor_div(a, 4);
			// Julian rule up to 1582-10-14 inclusive
			if (y < 1582 || (y == 1582 && m < 10) || (y == 1582 && m == 10 && d < 15))
				b = 0;
			whole = floor_div(1461 * (y + 4716), 4) + floor_div(306001 * (m + 1), 10000)
				+ d + b - MJD_OF_JD;
			r.mjd = whole[jcdc_pkg::MJD_W-1:0];
		end else begin
			z = longint'(c.mjd) + JD_OF_MJD0;
			greg = (z >= JD_FIRST_GREG);
			if (!greg) begin
				a = z;
			end else begin
				alpha = floor_div(4 * z - 7468865, 146097);
				a = z + 1 + alpha - floor_div(alpha, 4);
			end
			b = a + 1524;
			cc = floor_div(20 * b - 2442, 7305);
			dd = floor_div(1461 * cc, 4);
			e = floor_div(10000 * (b - dd), 306001);
			dom = b - dd - floor_div(306001 * e, 10000);
			mon = (e < 14) ? e - 1 : e - 13;
			yr = (mon > 2) ? cc - 4716 : cc - 4715;
			if (greg)
				leap = (floor_mod(yr, 4) == 0 && floor_mod(yr, 100) != 0)
					|| floor_mod(yr, 400) == 0;
			else
				leap = (floor_mod(yr, 4) == 0);
			k = leap ? 1 : 2;
			whole = floor_div(275 * mon, 9) - k * floor_div(mon + 9, 12) + dom - 30;
			r.year  = yr[jcdc_pkg::YEAR_W-1:0];
			r.month = mon[jcdc_pkg::MONTH_W-1:0];
			r.day   = dom[jcdc_pkg::DAY_W-1:0];
			r.doy   = whole[jcdc_pkg::DOY_W-1:0];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	// Random command with every field scrambled; callers override what matters
	function automatic conv_cmd_t noise_cmd();
		conv_cmd_t c;
		c.op    = 1'($urandom_range(0, 1));
		c.year  = jcdc_pkg::YEAR_W'($urandom);
		c.month = jcdc_pkg::MONTH_W'($urandom);
		c.day   = jcdc_pkg::DAY_W'($urandom);
		c.frac  = $urandom;
		c.mjd   = jcdc_pkg::MJD_W'($urandom);
		c.gap   = burst_run ? 0 : $urandom_range(0, LAST_GAP);
		return c;
	endfunction

	task automatic push_date(input int y, input int m, input int d, input logic [31:0] f);
		conv_cmd_t c;
		c = noise_cmd();
		c.op    = jcdc_pkg::OP_DATE_TO_MJD;
		c.year  = jcdc_pkg::YEAR_W'(y);
		c.month = jcdc_pkg::MONTH_W'(m);
		c.day   = jcdc_pkg::DAY_W'(d);
		c.frac  = f;
		pending_cmds.push_back(c);
	endtask

	task automatic push_mjd(input int v, input logic [31:0] f);
		conv_cmd_t c;
		c = noise_cmd();
		c.op   = jcdc_pkg::OP_MJD_TO_DATE;
		c.mjd  = jcdc_pkg::MJD_W'(v);
		c.frac = f;
		pending_cmds.push_back(c);
	endtask

	// Driver: change inputs on the falling edge. Hold a command until the
	// block takes it, then wait out the next command's pause and offer it.
	always @(negedge clk) begin
		if (arst_n && !(start && !beat_taken)) begin
			if (!gap_armed && pending_cmds.size() != 0) begin
				gap_left = pending_cmds[0].gap;
				gap_armed = 1'b1;
			end
			if (gap_left != 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (pending_cmds.size() != 0) begin
				drv_cmd = pending_cmds.pop_front();
				gap_armed = 1'b0;
				opcode      <= drv_cmd.op;
				cal_year    <= drv_cmd.year;
				cal_month   <= drv_cmd.month;
				cal_day     <= drv_cmd.day;
				in_fraction <= drv_cmd.frac;
				in_mjd_day  <= drv_cmd.mjd;
				start       <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: sample on the rising edge. Check any result beat against the
	// oldest prediction first, then record the command beat taken here.
	always @(posedge clk) begin
		if (!arst_n) begin
			beat_taken <= 1'b0;
		end else begin
			beat_taken <= start && !busy;
			if (done) begin
				if (expected_dates.size() == 0) begin
					$error("result beat with no conversion pending");
					fail_cnt++;
				end else begin
					want_res = expected_dates.pop_front();
					got_res = '{mjd: out_mjd_day, year: out_year, month: out_month,
						day: out_day, doy: out_day_of_year, frac: out_fraction};
					check_field("out_mjd_day", want_res.mjd, got_res.mjd);
					check_field("out_year", want_res.year, got_res.year);
					check_field("out_month", want_res.month, got_res.month);
					check_field("out_day", want_res.day, got_res.day);
					check_field("out_day_of_year", want_res.doy, got_res.doy);
					check_field("out_fraction", want_res.frac, got_res.frac);
				end
			end
			if (start && !busy) begin
				mon_cmd = '{op: opcode, year: cal_year, month: cal_month, day: cal_day,
					frac: in_fraction, mjd: in_mjd_day, gap: 0};
				expected_dates.push_back(convert_date(mon_cmd));
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int sel, y, m, d, mdays;
		// Directed: calendar switch, range ends, leap rules, malformed dates
		push_date(1582, 10, 15, 32'h0000_0000);
		push_date(1582, 10, 14, 32'h8000_0000);
		push_date(1582, 10, 4, 32'hFFFF_FFFF);
		push_date(1582, 10, 9, 32'h1234_5678);   // day that never existed
		push_date(1582, 9, 30, 32'h0);
		push_date(-4712, 1, 1, 32'h0);
		push_date(9999, 12, 31, 32'hFFFF_FFFF);
		push_date(2000, 2, 29, 32'h5555_5555);
		push_date(1900, 3, 1, 32'hAAAA_AAAA);
		push_date(2000, 1, 1, 32'h0);
		push_date(1999, 0, 0, 32'h1);             // month and day zero
		push_date(2023, 15, 31, 32'h7FFF_FFFF);   // month past December
		push_date(-16384, 2, 31, 32'h0);          // most negative year code
		push_date(16383, 12, 31, 32'hFFFF_FFFF);  // most positive year code
		push_mjd(-2400001, 32'h0);
		push_mjd(2973484, 32'hFFFF_FFFF);
		push_mjd(-100840, 32'h8000_0000);         // first Gregorian day
		push_mjd(-100841, 32'h0);                 // last Julian day
		push_mjd(0, 32'h0);
		push_mjd(51544, 32'h1);
		push_mjd(51909, 32'h0);                   // 2000-12-31, leap day of year
		push_mjd(15384, 32'h0);                   // 1900-12-31, century non-leap
		push_mjd(-4194304, 32'hFFFF_FFFF);
		push_mjd(4194303, 32'h0);

		// Random: mostly well-formed dates and MJDs, some near the switch,
		// the rest full-width noise. Flip between bursts and paced beats.
		for (int i = 0; i < 1000; i++) begin
			if (i % 32 == 0)
				burst_run = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				y = int'($urandom_range(0, 14711)) - 4712;
				m = $urandom_range(1, 12);
				mdays = (m == 2) ? 29 : (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
				d = $urandom_range(1, mdays);
				push_date(y, m, d, $urandom);
			end else if (sel < 50) begin
				y = int'($urandom_range(1581, 1583));
				m = $urandom_range(1, 12);
				d = $urandom_range(1, 31);
				push_date(y, m, d, $urandom);
			end else if (sel < 85) begin
				push_mjd(int'($urandom_range(0, 5373485)) - 2400001, $urandom);
			end else if (sel < 90) begin
				push_mjd(int'($urandom_range(0, 800)) - 100841 - 400, $urandom);
			end else begin
				pending_cmds.push_back(noise_cmd());
			end
		end

		// Release reset on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: every command in, every result out, then let the pipe settle
		while (pending_cmds.size() != 0 || start || expected_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && expected_dates.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
